// File: rtl/dcnt_pkg.sv
// ---------------------------------------------------------------------------
// dcnt_pkg: shared constants for the divisor count block
// Widths of the stream fields, the default value width and the count limit.
// ---------------------------------------------------------------------------
package dcnt_pkg;

  localparam int VALUE_BITS_DEF = 32;   // default width of the value used
  localparam int IN_W           = 32;   // width of the value field
  localparam int IN_TDATA_W     = 32;   // value field padded to bytes
  localparam int TOTAL_W        = 11;   // width of divisor_total
  localparam int OUT_TDATA_W    = 16;   // divisor_total padded to bytes

  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;  // saturation value

endpackage

// File: rtl/dcnt_div.sv
// ---------------------------------------------------------------------------
// dcnt_div: iterative restoring divider
// Produces quotient and remainder of an unsigned value by a trial divisor,
// one quotient bit per cycle; done pulses once the last quotient bit is in.
// ---------------------------------------------------------------------------
module dcnt_div #(
  parameter int NW = 32,
  parameter int DW = 17
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] dividend,
  input  logic [DW-1:0] divisor,
  output logic          done,
  output logic [NW-1:0] quotient,
  output logic [DW-1:0] remainder
);

  localparam int CW = $clog2(NW + 1);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [NW-1:0] quo;
  logic [DW-1:0] rem;

  logic [DW:0]   shifted;
  logic [DW+1:0] diff;
  logic          borrow;

  always_comb begin
    shifted = {rem, quo[NW-1]};
    diff    = {1'b0, shifted} - {2'b00, divisor};
    borrow  = diff[DW+1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(NW);
      end else if (busy) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
        end
      end
      done <= !start && busy && (cnt == CW'(1));
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
    end else if (busy) begin
      quo <= {quo[NW-2:0], ~borrow};
      // remainder stays below the divisor, so it fits DW bits
      rem <= borrow ? shifted[DW-1:0] : diff[DW-1:0];
    end
  end

  assign quotient  = quo;
  assign remainder = rem;

endmodule

// File: rtl/divisor_count.sv
// ---------------------------------------------------------------------------
// divisor_count: number of positive divisors by trial division
// Trial divisors run from 2 upward through one shared iterative divider.
// Each factor is divided out fully and the count is multiplied by its
// exponent plus one; a remainder above 1 at the end doubles the count.
//
//   channel  | dir | tdata fields (low bit up)       | tuser | tlast
//   s_axis   | in  | value[31:0]                     | -     | -
//   m_axis   | out | divisor_total[10:0], zero pad   | -     | -
//
// Each divide goes through S_DIV and S_WAIT to the one-bit-per-cycle divider
// (NW = min(VALUE_BITS, 32)); each trial divisor also passes S_CHECK and S_STEP.
// An item takes up to about 2^(NW/2) trial divisors.
// s_tready is high only while no value is being worked on; a result waiting
// on m_tready does not block the next transfer in, but holds the next finish.
// Reset (rst, synchronous) clears the sequencer and the output valid.
// ---------------------------------------------------------------------------
module divisor_count
  import dcnt_pkg::*;
#(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,   // value[31:0]
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata    // divisor_total[10:0], zeros above
);

  localparam int NW  = (VALUE_BITS < IN_W) ? VALUE_BITS : IN_W;
  localparam int DW  = NW / 2 + 1;
  localparam int SQW = 2 * DW;
  localparam int EW  = $clog2(NW + 2);
  localparam int PW  = TOTAL_W + EW;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_DIV   = 3'd2;
  localparam logic [2:0] S_WAIT  = 3'd3;
  localparam logic [2:0] S_STEP  = 3'd4;
  localparam logic [2:0] S_FIN   = 3'd5;
  localparam logic [2:0] S_OUT   = 3'd6;

  logic [2:0]         state;
  logic [NW-1:0]      n;
  logic [DW-1:0]      d;
  logic [SQW-1:0]     sq;
  logic [EW-1:0]      e;
  logic [TOTAL_W-1:0] total;

  logic               div_start;
  logic               div_done;
  logic [NW-1:0]      div_quo;
  logic [DW-1:0]      div_rem;

  logic [EW-1:0]      fac;
  logic [PW-1:0]      prod;
  logic [TOTAL_W-1:0] total_mul;
  logic               n_gt1;
  logic               trial_ok;

  dcnt_div #(
    .NW(NW),
    .DW(DW)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (n),
    .divisor   (d),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  assign div_start = (state == S_DIV);
  assign s_tready  = (state == S_IDLE);

  // shared saturating multiplier: exponent plus one, or two for a last prime
  always_comb begin
    fac       = (state == S_FIN) ? EW'(2) : e + EW'(1);
    prod      = PW'(total) * PW'(fac);
    total_mul = (prod > PW'(TOTAL_MAX)) ? TOTAL_MAX : prod[TOTAL_W-1:0];
    n_gt1     = (n > NW'(1));
    trial_ok  = n_gt1 && (sq <= SQW'(n));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      // a new result in S_OUT takes over the output slot
      if (m_tvalid && m_tready && state != S_OUT) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          state <= trial_ok ? S_DIV : S_FIN;
        end
        S_DIV: begin
          state <= S_WAIT;
        end
        S_WAIT: begin
          if (div_done) begin
            state <= S_STEP;
          end
        end
        S_STEP: begin
          state <= (div_rem == '0) ? S_DIV : S_CHECK;
        end
        S_FIN: begin
          state <= S_OUT;
        end
        S_OUT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        n     <= s_tdata[NW-1:0];
        d     <= DW'(2);
        sq    <= SQW'(4);
        e     <= '0;
        total <= TOTAL_W'(1);
      end
      S_STEP: begin
        if (div_rem == '0) begin
          // factor divides again, keep dividing it out
          n <= div_quo;
          e <= e + EW'(1);
        end else begin
          if (e != '0) begin
            total <= total_mul;
          end
          e  <= '0;
          sq <= sq + {{(SQW-DW-1){1'b0}}, d, 1'b1};
          d  <= d + DW'(1);
        end
      end
      S_FIN: begin
        if (n_gt1) begin
          total <= total_mul;
        end
      end
      S_OUT: begin
        if (!m_tvalid || m_tready) begin
          m_tdata <= OUT_TDATA_W'(total);
        end
      end
      default: begin
      end
    endcase
  end

  // the divider only finishes while the sequencer waits for it
  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == S_WAIT)
    else $error("divider finished outside wait state");

  // a new value is never taken while a result would be overwritten
  a_out_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT && m_tvalid && !m_tready) |=> state == S_OUT)
    else $error("result left before output was free");

  // every delivered count is at least one
  a_total_nonzero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[TOTAL_W-1:0] != '0)
    else $error("zero divisor count delivered");

  // the trial square tracks the trial divisor
  a_sq_tracks: assert property (@(posedge clk) disable iff (rst)
    state == S_CHECK |-> sq == SQW'(d) * SQW'(d))
    else $error("trial square out of step with divisor");

endmodule
